FILE: sv/lsbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbe_pkg
// Shared constants, operation codes and the halo distance table for the
// level-set border extrapolation unit.
// ----------------------------------------------------------------------------
package lsbe_pkg;

  localparam int MAX_X      = 64;
  localparam int MAX_Y      = 64;
  localparam int BORDER     = 3;
  localparam int PAD_W      = MAX_X + 2 * BORDER;
  localparam int PAD_H      = MAX_Y + 2 * BORDER;
  localparam int GRID_DEPTH = PAD_W * PAD_H;
  localparam int ADDR_W     = $clog2(GRID_DEPTH);

  localparam int RES_W   = 7;
  localparam int DATA_W  = 32;
  localparam int COORD_W = 8;
  localparam int POS_W   = 9;
  localparam int D_W     = $clog2(BORDER + 1);
  localparam int D2_W    = $clog2(2 * BORDER * BORDER + 1);
  localparam int DIST_W  = 20;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic CFG_X_RES = 1'b0;
  localparam logic CFG_Y_RES = 1'b1;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [RES_W-1:0]  res_t;

  // Unsigned Q4.16 round-to-nearest sqrt of dx*dx + dy*dy
  function automatic logic [DIST_W-1:0] dist_q16(input logic [D2_W-1:0] d2);
    logic [DIST_W-1:0] r;
    case (d2)
      5'd1:    r = 20'd65536;
      5'd2:    r = 20'd92682;
      5'd4:    r = 20'd131072;
      5'd5:    r = 20'd146543;
      5'd8:    r = 20'd185364;
      5'd9:    r = 20'd196608;
      5'd10:   r = 20'd207243;
      5'd13:   r = 20'd236293;
      5'd18:   r = 20'd278046;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/lsbe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbe_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module lsbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/lsbe_extrap_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbe_extrap_alu
// Shared extrapolation unit: moves a cell value away from zero by the halo
// distance and saturates to the signed 32-bit range. Result is registered.
// ----------------------------------------------------------------------------
module lsbe_extrap_alu (
  input  logic                    clk,
  input  lsbe_pkg::word_t         value,
  input  logic [lsbe_pkg::D2_W-1:0] d2,
  output lsbe_pkg::word_t         result_r
);
  import lsbe_pkg::*;

  logic [DIST_W-1:0]  dist_q;
  logic signed [DATA_W:0] v_ext;
  logic signed [DATA_W:0] d_ext;
  logic signed [DATA_W:0] sum;
  word_t              result_nxt;

  always_comb begin
    dist_q = dist_q16(d2);
    v_ext  = {value[DATA_W-1], value};
    d_ext  = signed'((DATA_W + 1)'(dist_q));
    if (value[DATA_W-1]) begin
      sum = v_ext - d_ext;
    end else begin
      sum = v_ext + d_ext;
    end
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      result_nxt = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      result_nxt = sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

endmodule

FILE: sv/level_set_border_extrapolation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// level_set_border_extrapolation_unit
// Level-set grid of signed Q16.16 cells with a halo filled by extrapolation.
// ----------------------------------------------------------------------------
// After reset the unit clears its 4900-word grid memory, one word a cycle, and
// holds busy high until the clear is done. A write, a NOP or an out-of-range
// access is registered and its result appears on the next cycle; a read also
// passes through a wait state because of the registered memory read port. A
// halo update walks every padded cell through one shared extrapolation unit:
// each halo cell takes the steps read, compute and write back, and each
// interior cell only the scan step. Each result is shown for one cycle
// with out_valid and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module level_set_border_extrapolation_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_operation,
  input  logic signed [lsbe_pkg::COORD_W-1:0] in_cell_x,
  input  logic signed [lsbe_pkg::COORD_W-1:0] in_cell_y,
  input  logic signed [lsbe_pkg::DATA_W-1:0]  in_write_value,
  output logic                           out_valid,
  output logic signed [lsbe_pkg::DATA_W-1:0]  out_read_value,
  output logic                           out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [lsbe_pkg::RES_W-1:0]     cfg_data
);
  import lsbe_pkg::*;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_RD_WAIT = 3'd2;
  localparam logic [2:0] ST_H_SCAN  = 3'd3;
  localparam logic [2:0] ST_H_LOAD  = 3'd4;
  localparam logic [2:0] ST_H_WRITE = 3'd5;

  logic [2:0] state_r, state_nxt;
  res_t       x_res_r, y_res_r;
  addr_t      clr_r, clr_nxt;
  res_t       i_r, i_nxt, j_r, j_nxt;
  addr_t      row_r, row_nxt;
  addr_t      dest_r, dest_nxt;
  logic [D2_W-1:0] d2_r, d2_nxt;
  logic       out_valid_r, out_valid_nxt;
  word_t      out_value_r, out_value_nxt;
  logic       out_status_r, out_status_nxt;

  res_t       eff_x, eff_y, sx, sy;
  logic signed [POS_W-1:0] px, py;
  logic       in_range;
  addr_t      acc_addr;
  res_t       src_x, src_y;
  logic [D_W-1:0] dx, dy;
  logic [D2_W-1:0] d2;
  addr_t      src_addr;
  logic       is_halo;

  logic       ram_we;
  addr_t      ram_waddr, ram_raddr;
  word_t      ram_wdata, ram_rdata;
  word_t      alu_result;

  assign cfg_ready      = 1'b1;
  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;

  always_comb begin
    eff_x = (x_res_r == '0) ? res_t'(1) : ((x_res_r > res_t'(MAX_X)) ? res_t'(MAX_X) : x_res_r);
    eff_y = (y_res_r == '0) ? res_t'(1) : ((y_res_r > res_t'(MAX_Y)) ? res_t'(MAX_Y) : y_res_r);
    sx    = eff_x + res_t'(2 * BORDER);
    sy    = eff_y + res_t'(2 * BORDER);

    px = POS_W'(in_cell_x) + POS_W'(BORDER);
    py = POS_W'(in_cell_y) + POS_W'(BORDER);
    in_range = !px[POS_W-1] && !py[POS_W-1] &&
               (px[RES_W-1:0] < sx) && (px[POS_W-2:RES_W] == '0) &&
               (py[RES_W-1:0] < sy) && (py[POS_W-2:RES_W] == '0);
    acc_addr = addr_t'(px[RES_W-1:0]) * addr_t'(PAD_H) + addr_t'(py[RES_W-1:0]);

    if (i_r < res_t'(BORDER)) begin
      dx    = D_W'(res_t'(BORDER) - i_r);
      src_x = res_t'(BORDER);
    end else if ((sx - i_r) <= res_t'(BORDER)) begin
      dx    = D_W'(i_r - (sx - res_t'(1 + BORDER)));
      src_x = sx - res_t'(1 + BORDER);
    end else begin
      dx    = '0;
      src_x = i_r;
    end
    if (j_r < res_t'(BORDER)) begin
      dy    = D_W'(res_t'(BORDER) - j_r);
      src_y = res_t'(BORDER);
    end else if ((sy - j_r) <= res_t'(BORDER)) begin
      dy    = D_W'(j_r - (sy - res_t'(1 + BORDER)));
      src_y = sy - res_t'(1 + BORDER);
    end else begin
      dy    = '0;
      src_y = j_r;
    end
    is_halo  = (dx != '0) || (dy != '0);
    d2       = D2_W'(dx) * D2_W'(dx) + D2_W'(dy) * D2_W'(dy);
    src_addr = addr_t'(src_x) * addr_t'(PAD_H) + addr_t'(src_y);
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    row_nxt        = row_r;
    dest_nxt       = dest_r;
    d2_nxt         = d2_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = '0;
    out_status_nxt = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = acc_addr;
    ram_wdata      = in_write_value;
    ram_raddr      = acc_addr;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + addr_t'(1);
        if (clr_r == addr_t'(GRID_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          unique case (in_operation)
            OP_WRITE: begin
              ram_we         = in_range;
              out_valid_nxt  = 1'b1;
              out_status_nxt = !in_range;
            end
            OP_READ: begin
              if (in_range) begin
                state_nxt = ST_RD_WAIT;
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = 1'b1;
              end
            end
            OP_UPDATE: begin
              i_nxt     = '0;
              j_nxt     = '0;
              row_nxt   = '0;
              state_nxt = ST_H_SCAN;
            end
            OP_NOP: begin
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_RD_WAIT: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = ram_rdata;
        state_nxt     = ST_IDLE;
      end
      ST_H_SCAN: begin
        ram_raddr = src_addr;
        dest_nxt  = row_r + addr_t'(j_r);
        d2_nxt    = d2;
        if (is_halo) begin
          state_nxt = ST_H_LOAD;
        end else begin
          j_nxt = j_r + res_t'(1);
        end
      end
      ST_H_LOAD: begin
        state_nxt = ST_H_WRITE;
      end
      ST_H_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = dest_r;
        ram_wdata = alu_result;
        j_nxt     = j_r + res_t'(1);
        state_nxt = ST_H_SCAN;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // advance to the next row or finish the sweep
    if ((state_r == ST_H_WRITE || (state_r == ST_H_SCAN && !is_halo)) &&
        (j_r == sy - res_t'(1))) begin
      j_nxt = '0;
      if (i_r == sx - res_t'(1)) begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end else begin
        i_nxt   = i_r + res_t'(1);
        row_nxt = row_r + addr_t'(PAD_H);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      x_res_r     <= res_t'(MAX_X);
      y_res_r     <= res_t'(MAX_Y);
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      row_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      row_r       <= row_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_X_RES) begin
          x_res_r <= cfg_data;
        end else begin
          y_res_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    dest_r       <= dest_nxt;
    d2_r         <= d2_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  lsbe_ram #(
    .WIDTH(DATA_W),
    .DEPTH(GRID_DEPTH)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  lsbe_extrap_alu u_alu (
    .clk     (clk),
    .value   (ram_rdata),
    .d2      (d2_r),
    .result_r(alu_result)
  );

endmodule
